### sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 stream hasher: hash and schedule
// word groups, the round constants, the initial hash value and the control
// structs between the byte front end and the compression engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BLOCK_BITS = 512;

  typedef logic [BLOCK_BITS-1:0] block_t;
  typedef logic [7:0][31:0]      hash_t;   // index 0 is word a / H0
  typedef logic [15:0][31:0]     sched_t;  // index 0 is the oldest word

  typedef struct packed {
    logic start;  // load block and chaining words, run 64 rounds
    logic init;   // reload the initial hash value
  } cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;   // chaining words take the new sum at this edge
  } cmp_stat_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam hash_t HASH_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

### sv/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// One SHA-256 round: working variable update plus one message schedule step
// on a sliding 16-word window.
// ----------------------------------------------------------------------------
module sha256_round
  import sha256_pkg::*;
(
  input  hash_t      v_i,
  input  sched_t     w_i,
  input  logic [5:0] rnd_i,
  output hash_t      v_o,
  output sched_t     w_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] sum1, ch, t1, sum0, maj, t2, ws0, ws1;

  always_comb begin
    sum1 = rotr(v_i[4], 6) ^ rotr(v_i[4], 11) ^ rotr(v_i[4], 25);
    ch   = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    t1   = v_i[7] + sum1 + ch + ROUND_K[rnd_i] + w_i[0];
    sum0 = rotr(v_i[0], 2) ^ rotr(v_i[0], 13) ^ rotr(v_i[0], 22);
    maj  = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t2   = sum0 + maj;

    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;

    // next schedule word enters at the top, window slides down by one
    ws0 = rotr(w_i[1], 7) ^ rotr(w_i[1], 18) ^ (w_i[1] >> 3);
    ws1 = rotr(w_i[14], 17) ^ rotr(w_i[14], 19) ^ (w_i[14] >> 10);
    for (int i = 0; i < 15; i++) begin
      w_o[i] = w_i[i+1];
    end
    w_o[15] = w_i[0] + ws0 + w_i[9] + ws1;
  end

endmodule

### sv/sha256_compress.sv
// ----------------------------------------------------------------------------
// sha256_compress
// Iterative compression engine: one round per cycle through a shared round
// unit, then a fold of the result into the chaining words.
// ----------------------------------------------------------------------------
module sha256_compress
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cmp_ctrl_t ctrl_i,
  input  block_t    block_i,
  output hash_t     hash_o,
  output cmp_stat_t stat_o
);

  typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} state_t;

  localparam logic [5:0] LAST_RND = 6'd63;

  state_t     state_r;
  logic [5:0] rnd_r;
  hash_t      v_r, h_r, v_nxt;
  sched_t     w_r, w_nxt, blk_win;

  sha256_round u_round (
    .v_i   (v_r),
    .w_i   (w_r),
    .rnd_i (rnd_r),
    .v_o   (v_nxt),
    .w_o   (w_nxt)
  );

  // first byte of the block is the top byte of word 0
  always_comb begin
    for (int j = 0; j < 16; j++) begin
      blk_win[j] = block_i[BLOCK_BITS-1-32*j -: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      h_r     <= HASH_IV;
    end else begin
      case (state_r)
        C_IDLE: begin
          if (ctrl_i.start) begin
            v_r     <= h_r;
            w_r     <= blk_win;
            rnd_r   <= '0;
            state_r <= C_ROUND;
          end else if (ctrl_i.init) begin
            h_r <= HASH_IV;
          end
        end
        C_ROUND: begin
          v_r   <= v_nxt;
          w_r   <= w_nxt;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == LAST_RND) begin
            state_r <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
          end
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign hash_o      = h_r;
  assign stat_o.busy = (state_r != C_IDLE);
  assign stat_o.done = (state_r == C_ADD);

endmodule

### sv/sha256_stream_hasher.sv
// A byte beat that does not fill a block is absorbed straight away.
// A beat that fills a block holds in_tready low through the kick, the
// 64 rounds (one per cycle through the shared round unit) and the fold.
// End of message: one pad byte per cycle up to the end of the block, a
// compression run per final block (one or two), then 8 digest beats on the out side.
// Reset (rst_n low, synchronous): initial hash loaded, counts cleared, idle.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-serial SHA-256: collects message bytes in a 64-byte shift line, pads
// the message byte by byte through the same path, runs the compression
// engine on each full block and streams out the eight digest words.
// ----------------------------------------------------------------------------
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  // digest output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  typedef enum logic [2:0] {S_IN, S_KICK, S_WAIT, S_PAD, S_OUT} state_t;

  localparam logic [2:0] LAST_IDX = 3'd7;

  state_t      state_r;
  block_t      buf_r;        // shift line, oldest byte on top
  logic [5:0]  fill_r;
  logic [5:0]  fill_inc;
  logic [63:0] bitcnt_r;
  logic        pad_r;        // padding of this message under way
  logic        first_r;      // next pad byte is the end marker
  logic        len_r;        // pad bytes now carry the bit length
  logic        final_r;      // block in flight is the last of the message
  logic [2:0]  idx_r;
  logic [7:0]  pad_byte;

  cmp_ctrl_t   cmp_ctrl;
  cmp_stat_t   cmp_stat;
  hash_t       hash;

  sha256_compress u_compress (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (cmp_ctrl),
    .block_i (buf_r),
    .hash_o  (hash),
    .stat_o  (cmp_stat)
  );

  assign fill_inc = fill_r + 6'd1;

  // length bytes come out of the top of the count, which shifts left
  assign pad_byte = first_r ? PAD_MARK : (len_r ? bitcnt_r[63:56] : 8'h00);

  assign in_tready = (state_r == S_IN) && !cmp_stat.busy;

  always_comb begin
    cmp_ctrl       = '0;
    cmp_ctrl.start = (state_r == S_KICK);
    // reload the initial hash as the last digest beat leaves
    cmp_ctrl.init  = (state_r == S_OUT) && out_tready && (idx_r == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IN;
      fill_r   <= '0;
      bitcnt_r <= '0;
      pad_r    <= 1'b0;
      first_r  <= 1'b0;
      len_r    <= 1'b0;
      final_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      case (state_r)
        S_IN: begin
          if (in_tvalid && in_tready) begin
            if (in_tuser) begin
              // absorb the byte first, close the message after it
              buf_r    <= {buf_r[BLOCK_BITS-9:0], in_tdata};
              fill_r   <= fill_inc;
              bitcnt_r <= bitcnt_r + 64'd8;
              if (fill_inc == '0) begin
                state_r <= S_KICK;
              end else if (in_tlast) begin
                state_r <= S_PAD;
              end
              if (in_tlast) begin
                pad_r   <= 1'b1;
                first_r <= 1'b1;
              end
            end else if (in_tlast) begin
              state_r <= S_PAD;
              pad_r   <= 1'b1;
              first_r <= 1'b1;
            end
          end
        end
        S_KICK: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (cmp_stat.done) begin
            if (final_r) begin
              state_r <= S_OUT;
              idx_r   <= '0;
            end else if (pad_r) begin
              state_r <= S_PAD;
            end else begin
              state_r <= S_IN;
            end
          end
        end
        S_PAD: begin
          buf_r   <= {buf_r[BLOCK_BITS-9:0], pad_byte};
          fill_r  <= fill_inc;
          first_r <= 1'b0;
          if (len_r) begin
            bitcnt_r <= {bitcnt_r[55:0], 8'h00};
          end
          if (fill_inc == '0) begin
            state_r <= S_KICK;
            if (len_r) begin
              final_r <= 1'b1;
              len_r   <= 1'b0;
              pad_r   <= 1'b0;
            end
          end else if (!len_r && fill_inc == LEN_POS) begin
            len_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_tready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == LAST_IDX) begin
              state_r  <= S_IN;
              final_r  <= 1'b0;
              bitcnt_r <= '0;
            end
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  // digest words are read straight from the chaining words, which hold
  // still for the whole output phase
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = hash[idx_r];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == LAST_IDX);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while digest beats pending");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_stat.busy |-> !in_tready)
    else $error("input ready while compression runs");

  a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready for a new message after the last digest beat");

  a_pad_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (fill_r == '0))
    else $error("digest output with a partly filled block");
`endif

endmodule
